/* hdl/pfc_pkg.sv */
`default_nettype none

package pfc_pkg;

	localparam int SAMPLE_BITS   = 10;
	localparam int INTEGRAL_BITS = 40;

	localparam int GAIN_BITS  = 16;
	localparam int DIST_BITS  = 3;
	localparam int MEAS_BITS  = 10;
	localparam int ERR_BITS   = 18;
	localparam int DRIVE_BITS = 8;

	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	localparam logic signed [GAIN_BITS-1:0] SETPOINT_RST = 16'sd7680;
	localparam logic [GAIN_BITS-1:0]        KP_RST       = 16'd30874;
	localparam logic [GAIN_BITS-1:0]        KIH_RST      = 16'd307;
	localparam logic [GAIN_BITS-1:0]        KDR_RST      = 16'd1536;

	// sample scaling: (s - 20) * 165 / 338 - 40
	localparam int OFFSET_ZERO = 20;
	localparam int OFFSET_DEG  = 40;
	localparam int SCALE_NUM   = 165;
	localparam int SCALE_DEN   = 338;
	localparam int SCALE_RECIP = 49636;
	localparam int SCALE_SHIFT = 24;
	localparam int RECIP_BITS  = 16;
	localparam int A_BITS      = SAMPLE_BITS + 8;
	localparam int QY_BITS     = A_BITS + RECIP_BITS - SCALE_SHIFT;
	localparam int QD_BITS     = 9;
	localparam int Q_BITS      = (QY_BITS > QD_BITS) ? QY_BITS : QD_BITS;
	localparam int YW          = Q_BITS + 3;
	localparam int MEAS_MAX    = (1 << (MEAS_BITS - 1)) - 1;
	localparam int MEAS_MIN    = -(1 << (MEAS_BITS - 1));

	localparam int Q8_BITS = 8;
	localparam int ERR_W   = ERR_BITS + 1;
	localparam int ERR_MAX = (1 << (ERR_BITS - 1)) - 1;
	localparam int ERR_MIN = -(1 << (ERR_BITS - 1));

	localparam int IW1 = INTEGRAL_BITS + 1;
	localparam logic signed [INTEGRAL_BITS-1:0] INTEG_MAX =
		{1'b0, {(INTEGRAL_BITS-1){1'b1}}};
	localparam logic signed [INTEGRAL_BITS-1:0] INTEG_MIN =
		{1'b1, {(INTEGRAL_BITS-1){1'b0}}};

	localparam int FRAC_BITS = 16;
	localparam int FF_SHIFT  = 8;
	localparam int ACC_BITS  = ((INTEGRAL_BITS > 36) ? INTEGRAL_BITS : 36) + 2;
	localparam int U_BITS    = ACC_BITS - FRAC_BITS;
	localparam int V_BITS    = U_BITS + 1;

	// drive mapping: (u + 4098) * 255 / 8196
	localparam int MAP_BIAS       = 4098;
	localparam int MAP_NUM        = 255;
	localparam int MAP_DEN        = 8196;
	localparam int MAP_RECIP      = 524032;
	localparam int MAP_SHIFT      = 32;
	localparam int MAP_V_MAX      = 8228;
	localparam int MAP_V_CLIP_LO  = -33;
	localparam int MAP_V_BITS     = 14;
	localparam int W_BITS         = 22;
	localparam int RD_BITS        = W_BITS + 1;
	localparam int DEN_HI_SHIFT   = 13;
	localparam int DEN_LO_SHIFT   = 2;

	localparam int MUL_A_BITS = ((A_BITS > W_BITS) ? A_BITS : W_BITS) + 1;
	localparam int MUL_B_BITS = 21;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

	localparam int STEP_BITS = 4;
	typedef logic [STEP_BITS-1:0] step_t;
	localparam step_t STEP_DRIVE = 4'd15;

	typedef enum logic [1:0] {
		REG_SETPOINT = 2'd0,
		REG_KP       = 2'd1,
		REG_KIH      = 2'd2,
		REG_KDR      = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		MUL_NONE    = 4'd0,
		MUL_SCALE   = 4'd1,
		MUL_RECIP_Y = 4'd2,
		MUL_QY      = 4'd3,
		MUL_P       = 4'd4,
		MUL_I       = 4'd5,
		MUL_D       = 4'd6,
		MUL_FF      = 4'd7,
		MUL_MAP     = 4'd8,
		MUL_RECIP_D = 4'd9
	} mul_op_t;

	typedef enum logic [3:0] {
		DP_NOP      = 4'd0,
		DP_SAVE_A   = 4'd1,
		DP_SAVE_QY  = 4'd2,
		DP_MEAS     = 4'd3,
		DP_ERROR    = 4'd4,
		DP_DIFF     = 4'd5,
		DP_ACC_LOAD = 4'd6,
		DP_INTEG    = 4'd7,
		DP_ACC_ADD  = 4'd8,
		DP_ACC_FF   = 4'd9,
		DP_ACC_I    = 4'd10,
		DP_BIAS     = 4'd11,
		DP_SAVE_W   = 4'd12,
		DP_QD       = 4'd13,
		DP_DRIVE    = 4'd14
	} dp_op_t;

	typedef struct packed {
		mul_op_t mul_op;
		dp_op_t  dp_op;
		logic    jump_out;
		step_t   target;
		logic    last;
	} ctrl_word_t;

	typedef struct packed {
		ctrl_word_t word;
		logic       busy;
		logic       fire;
	} seq_ctrl_t;

	function automatic ctrl_word_t ucode(input step_t pc);
		ctrl_word_t w;
		w.mul_op   = MUL_NONE;
		w.dp_op    = DP_NOP;
		w.jump_out = 1'b0;
		w.target   = STEP_DRIVE;
		w.last     = 1'b0;
		unique case (pc)
			4'd0: w.mul_op = MUL_SCALE;
			4'd1: begin
				w.mul_op = MUL_RECIP_Y;
				w.dp_op  = DP_SAVE_A;
			end
			4'd2: begin
				w.mul_op = MUL_QY;
				w.dp_op  = DP_SAVE_QY;
			end
			4'd3: w.dp_op = DP_MEAS;
			4'd4: w.dp_op = DP_ERROR;
			4'd5: begin
				w.mul_op = MUL_P;
				w.dp_op  = DP_DIFF;
			end
			4'd6: begin
				w.mul_op = MUL_I;
				w.dp_op  = DP_ACC_LOAD;
			end
			4'd7: begin
				w.mul_op = MUL_D;
				w.dp_op  = DP_INTEG;
			end
			4'd8: begin
				w.mul_op = MUL_FF;
				w.dp_op  = DP_ACC_ADD;
			end
			4'd9:  w.dp_op = DP_ACC_FF;
			4'd10: w.dp_op = DP_ACC_I;
			4'd11: w.dp_op = DP_BIAS;
			4'd12: begin
				w.mul_op   = MUL_MAP;
				w.jump_out = 1'b1;
			end
			4'd13: begin
				w.mul_op = MUL_RECIP_D;
				w.dp_op  = DP_SAVE_W;
			end
			4'd14: w.dp_op = DP_QD;
			default: begin
				w.dp_op = DP_DRIVE;
				w.last  = 1'b1;
			end
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hdl/pfc_if.sv */
`default_nettype none

interface pfc_sample_if import pfc_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [SAMPLE_BITS-1:0]        raw_sample;
	logic signed [DIST_BITS-1:0]   disturbance;

	modport source (output valid, raw_sample, disturbance, input ready);
	modport sink   (input valid, raw_sample, disturbance, output ready);
endinterface

interface pfc_result_if import pfc_pkg::*; ();
	logic                          valid;
	logic                          ready;
	logic [DRIVE_BITS-1:0]         drive;
	logic signed [MEAS_BITS-1:0]   measured_value;
	logic signed [ERR_BITS-1:0]    control_error;
	logic                          drive_clipped;

	modport source (output valid, drive, measured_value, control_error, drive_clipped,
		input ready);
	modport sink   (input valid, drive, measured_value, control_error, drive_clipped,
		output ready);
endinterface

`default_nettype wire

/* hdl/pfc_sequencer.sv */
`default_nettype none

module pfc_sequencer import pfc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic out_free,
	input  wire logic map_in_range,
	output seq_ctrl_t seq
);

	step_t      pc_q;
	logic       busy_q;
	ctrl_word_t word;

	assign word      = ucode(pc_q);
	assign seq.word  = word;
	assign seq.busy  = busy_q;
	assign seq.fire  = busy_q && (!word.last || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q   <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			pc_q   <= '0;
			busy_q <= 1'b1;
		end else if (seq.fire) begin
			priority if (word.last) begin
				busy_q <= 1'b0;
			end else if (word.jump_out && !map_in_range) begin
				pc_q <= word.target;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* hdl/pid_feedforward_controller_unit.sv */
`default_nettype none

// PID controller with disturbance feedforward. Each input word carries a raw converter
// sample and an expected disturbance; the block scales the sample to degrees, forms the
// Q10.8 error against the setpoint, updates a saturating Q24.16 integral and the stored
// error, sums the P, I, D and feedforward terms and maps the result to an 8-bit drive
// with a clip flag. One word is worked on at a time by a 16-step microprogram that runs
// every multiply through one shared registered multiplier; the divide steps are skipped
// when the biased sum is negative or above the mapping range. The last step waits until
// the output register is free, and the next word is taken the cycle after its result is
// registered.
// A finished result waits in the output register while the next word is being worked on.
// Gains and setpoint sit on the APB port at byte addresses 0, 4, 8, 12 and should only be
// written while no word is in flight.

module pid_feedforward_controller_unit import pfc_pkg::*; (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     psel,
	input  wire logic                     penable,
	input  wire logic                     pwrite,
	input  wire logic [APB_ADDR_BITS-1:0] paddr,
	input  wire logic [APB_DATA_BITS-1:0] pwdata,
	output logic      [APB_DATA_BITS-1:0] prdata,
	output logic                          pready,
	pfc_sample_if.sink                    sample_ch,
	pfc_result_if.source                  result_ch
);

	// configuration registers
	logic signed [GAIN_BITS-1:0] setpoint_q;
	logic [GAIN_BITS-1:0]        kp_q;
	logic [GAIN_BITS-1:0]        kih_q;
	logic [GAIN_BITS-1:0]        kdr_q;
	reg_idx_t                    reg_idx;

	// sequencer
	seq_ctrl_t seq;
	logic      start;
	logic      out_free;
	logic      map_in_range;

	// input word
	logic                        samp_neg;
	logic [SAMPLE_BITS-1:0]      samp_mag;
	logic                        samp_neg_q;
	logic [SAMPLE_BITS-1:0]      samp_mag_q;
	logic signed [DIST_BITS-1:0] dist_q;

	// datapath
	logic signed [MUL_A_BITS-1:0]    mul_a;
	logic signed [MUL_B_BITS-1:0]    mul_b;
	logic signed [PROD_BITS-1:0]     prod_q;
	logic [A_BITS-1:0]               a_q;
	logic [Q_BITS-1:0]               q_q;
	logic signed [MEAS_BITS-1:0]     y_q;
	logic signed [ERR_BITS-1:0]      e_q;
	logic signed [ERR_BITS-1:0]      last_q;
	logic signed [ERR_W-1:0]         diff_q;
	logic signed [INTEGRAL_BITS-1:0] integ_q;
	logic signed [ACC_BITS-1:0]      acc_q;
	logic signed [V_BITS-1:0]        v_q;
	logic [W_BITS-1:0]               w_q;

	logic [A_BITS-1:0]               rem_y;
	logic [Q_BITS-1:0]               qy_fix;
	logic signed [YW-1:0]            y_mag;
	logic signed [YW-1:0]            y_full;
	logic signed [MEAS_BITS-1:0]     meas_sat;
	logic signed [ERR_W-1:0]         err_full;
	logic signed [ERR_BITS-1:0]      err_sat;
	logic signed [IW1-1:0]           integ_full;
	logic signed [INTEGRAL_BITS-1:0] integ_next;
	logic signed [U_BITS-1:0]        u_hi;
	logic                            u_up;
	logic signed [V_BITS-1:0]        v_next;
	logic [RD_BITS-1:0]              rem_d;
	logic                            drive_up;
	logic [DRIVE_BITS-1:0]           drive_map;
	logic [DRIVE_BITS-1:0]           drive_sat;
	logic                            clip;

	// output register
	logic                        out_valid_q;
	logic [DRIVE_BITS-1:0]       out_drive_q;
	logic signed [MEAS_BITS-1:0] out_meas_q;
	logic signed [ERR_BITS-1:0]  out_err_q;
	logic                        out_clip_q;

	// apb
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q <= SETPOINT_RST;
			kp_q       <= KP_RST;
			kih_q      <= KIH_RST;
			kdr_q      <= KDR_RST;
		end else if (psel && penable && pwrite) begin
			unique case (reg_idx)
				REG_SETPOINT: setpoint_q <= $signed(pwdata[GAIN_BITS-1:0]);
				REG_KP:       kp_q       <= pwdata[GAIN_BITS-1:0];
				REG_KIH:      kih_q      <= pwdata[GAIN_BITS-1:0];
				REG_KDR:      kdr_q      <= pwdata[GAIN_BITS-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_SETPOINT: prdata = APB_DATA_BITS'(setpoint_q);
			REG_KP:       prdata = APB_DATA_BITS'(kp_q);
			REG_KIH:      prdata = APB_DATA_BITS'(kih_q);
			REG_KDR:      prdata = APB_DATA_BITS'(kdr_q);
		endcase
	end

	// handshake
	assign start           = sample_ch.valid && !seq.busy;
	assign sample_ch.ready = !seq.busy;
	assign out_free        = !out_valid_q || result_ch.ready;

	pfc_sequencer u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.out_free     (out_free),
		.map_in_range (map_in_range),
		.seq          (seq)
	);

	// input capture: sign and magnitude of s - 20
	assign samp_neg = sample_ch.raw_sample < SAMPLE_BITS'(OFFSET_ZERO);
	assign samp_mag = samp_neg ? SAMPLE_BITS'(OFFSET_ZERO) - sample_ch.raw_sample
		: sample_ch.raw_sample - SAMPLE_BITS'(OFFSET_ZERO);

	always_ff @(posedge clk) begin
		if (start) begin
			samp_neg_q <= samp_neg;
			samp_mag_q <= samp_mag;
			dist_q     <= sample_ch.disturbance;
		end
	end

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (seq.word.mul_op)
			MUL_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			MUL_SCALE: begin
				mul_a = MUL_A_BITS'(samp_mag_q);
				mul_b = MUL_B_BITS'(SCALE_NUM);
			end
			MUL_RECIP_Y: begin
				mul_a = MUL_A_BITS'(prod_q[A_BITS-1:0]);
				mul_b = MUL_B_BITS'(SCALE_RECIP);
			end
			MUL_QY: begin
				mul_a = MUL_A_BITS'(prod_q[SCALE_SHIFT+QY_BITS-1:SCALE_SHIFT]);
				mul_b = MUL_B_BITS'(SCALE_DEN);
			end
			MUL_P: begin
				mul_a = MUL_A_BITS'(kp_q);
				mul_b = MUL_B_BITS'(e_q);
			end
			MUL_I: begin
				mul_a = MUL_A_BITS'(kih_q);
				mul_b = MUL_B_BITS'(e_q);
			end
			MUL_D: begin
				mul_a = MUL_A_BITS'(kdr_q);
				mul_b = MUL_B_BITS'(diff_q);
			end
			MUL_FF: begin
				mul_a = MUL_A_BITS'(kp_q);
				mul_b = MUL_B_BITS'(dist_q);
			end
			MUL_MAP: begin
				mul_a = MUL_A_BITS'(v_q[MAP_V_BITS-1:0]);
				mul_b = MUL_B_BITS'(MAP_NUM);
			end
			MUL_RECIP_D: begin
				mul_a = MUL_A_BITS'(prod_q[W_BITS-1:0]);
				mul_b = MUL_B_BITS'(MAP_RECIP);
			end
		endcase
	end

	// measurement: quotient correction, sign, offsets, saturation
	assign rem_y  = a_q - prod_q[A_BITS-1:0];
	assign qy_fix = q_q + Q_BITS'(rem_y >= A_BITS'(SCALE_DEN));
	assign y_mag  = YW'(qy_fix);
	assign y_full = (samp_neg_q ? -y_mag : y_mag) - YW'(OFFSET_DEG) + YW'(dist_q);
	assign meas_sat = (y_full > YW'(MEAS_MAX)) ? MEAS_BITS'(MEAS_MAX)
		: (y_full < YW'(MEAS_MIN)) ? MEAS_BITS'(MEAS_MIN) : MEAS_BITS'(y_full);

	// error in q10.8
	assign err_full = ERR_W'(setpoint_q) - ERR_W'($signed({y_q, {Q8_BITS{1'b0}}}));
	assign err_sat  = (err_full > ERR_W'(ERR_MAX)) ? ERR_BITS'(ERR_MAX)
		: (err_full < ERR_W'(ERR_MIN)) ? ERR_BITS'(ERR_MIN) : ERR_BITS'(err_full);

	// saturating integral
	assign integ_full = IW1'(integ_q) + IW1'(prod_q);
	assign integ_next = (integ_full[IW1-1] != integ_full[IW1-2])
		? (integ_full[IW1-1] ? INTEG_MIN : INTEG_MAX) : integ_full[IW1-2:0];

	// truncate toward zero and bias
	assign u_hi   = acc_q[ACC_BITS-1:FRAC_BITS];
	assign u_up   = acc_q[ACC_BITS-1] && (acc_q[FRAC_BITS-1:0] != '0);
	assign v_next = V_BITS'(u_hi) + $signed(V_BITS'(u_up)) + V_BITS'(MAP_BIAS);

	assign map_in_range = !v_q[V_BITS-1] && (v_q <= V_BITS'(MAP_V_MAX));

	// drive quotient correction and saturation
	assign rem_d = RD_BITS'(w_q) - (RD_BITS'(q_q) << DEN_HI_SHIFT)
		- (RD_BITS'(q_q) << DEN_LO_SHIFT);
	assign drive_up  = rem_d >= RD_BITS'(MAP_DEN);
	assign drive_map = q_q[DRIVE_BITS-1:0] + DRIVE_BITS'(drive_up);
	assign drive_sat = v_q[V_BITS-1] ? '0
		: (v_q > V_BITS'(MAP_V_MAX)) ? '1 : drive_map;
	assign clip = (v_q <= V_BITS'(MAP_V_CLIP_LO)) || (v_q > V_BITS'(MAP_V_MAX));

	always_ff @(posedge clk) begin
		if (seq.fire) begin
			prod_q <= mul_a * mul_b;
			unique case (seq.word.dp_op)
				DP_NOP, DP_INTEG: begin
				end
				DP_SAVE_A:   a_q <= prod_q[A_BITS-1:0];
				DP_SAVE_QY:  q_q <= Q_BITS'(prod_q[SCALE_SHIFT+QY_BITS-1:SCALE_SHIFT]);
				DP_MEAS:     y_q <= meas_sat;
				DP_ERROR:    e_q <= err_sat;
				DP_DIFF:     diff_q <= ERR_W'(e_q) - ERR_W'(last_q);
				DP_ACC_LOAD: acc_q <= ACC_BITS'(prod_q);
				DP_ACC_ADD:  acc_q <= acc_q + ACC_BITS'(prod_q);
				DP_ACC_FF:   acc_q <= acc_q + (ACC_BITS'(prod_q) <<< FF_SHIFT);
				DP_ACC_I:    acc_q <= acc_q + ACC_BITS'(integ_q);
				DP_BIAS:     v_q <= v_next;
				DP_SAVE_W:   w_q <= prod_q[W_BITS-1:0];
				DP_QD:       q_q <= Q_BITS'(prod_q[MAP_SHIFT+QD_BITS-1:MAP_SHIFT]);
				DP_DRIVE: begin
					out_drive_q <= drive_sat;
					out_clip_q  <= clip;
					out_meas_q  <= y_q;
					out_err_q   <= e_q;
				end
			endcase
		end
	end

	// controller state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= '0;
			integ_q <= '0;
		end else if (seq.fire) begin
			if (seq.word.dp_op == DP_DIFF) begin
				last_q <= e_q;
			end
			if (seq.word.dp_op == DP_INTEG) begin
				integ_q <= integ_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq.fire && seq.word.last) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_ch.valid          = out_valid_q;
	assign result_ch.drive          = out_drive_q;
	assign result_ch.measured_value = out_meas_q;
	assign result_ch.control_error  = out_err_q;
	assign result_ch.drive_clipped  = out_clip_q;

endmodule

`default_nettype wire
